// ----- rtl/descriptor_slot_allocator_assert.svh -----
// assertion macros for the descriptor slot allocator
// expects clk and rst_n in the scope of each use
`ifndef DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH
`define DESCRIPTOR_SLOT_ALLOCATOR_ASSERT_SVH

`define DSA_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`define DSA_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

`define DSA_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/dsa_pkg.sv -----
// types, codes and constants of the descriptor slot allocator
// no dependencies
package dsa_pkg;

    localparam int MAX_SLOTS_DEF = 1024;

    localparam int HEAP_W     = 11;
    localparam int STRIDE_W   = 13;
    localparam int ADDR_W     = 64;
    localparam int IDX_W      = 10;
    localparam int CFG_IDX_W  = 3;
    localparam int CFG_DATA_W = 64;

    localparam logic [STRIDE_W-1:0] STRIDE_RST = 13'd32;

    localparam logic [CFG_IDX_W-1:0] REG_HEAP_SLOTS     = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SLOT_STRIDE    = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_CPU_BASE_ADDR  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_GPU_BASE_ADDR  = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_SHADER_VISIBLE = 3'd4;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef enum logic [2:0] {
        ST_OK          = 3'd0,
        ST_HEAP_FULL   = 3'd1,
        ST_RANGE       = 3'd2,
        ST_INVALID     = 3'd3,
        ST_STACK_FULL  = 3'd4
    } status_t;

    typedef struct packed {
        logic [HEAP_W-1:0]   heap_slots;
        logic [STRIDE_W-1:0] slot_stride;
        logic [ADDR_W-1:0]   cpu_base_addr;
        logic [ADDR_W-1:0]   gpu_base_addr;
        logic                shader_visible;
    } cfg_t;

    typedef enum logic [8:0] {
        S_IDLE = 9'b000000001,
        S_POP  = 9'b000000010,
        S_CHK  = 9'b000000100,
        S_ADD  = 9'b000001000,
        S_SUB  = 9'b000010000,
        S_RNG  = 9'b000100000,
        S_DIV  = 9'b001000000,
        S_PUSH = 9'b010000000,
        S_DONE = 9'b100000000
    } state_t;

endpackage

// ----- rtl/dsa_req_if.sv -----
// request channel of the descriptor slot allocator
// depends on dsa_pkg
interface dsa_req_if import dsa_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              cmd;
    logic [ADDR_W-1:0] free_cpu_addr;

    modport source (output valid, output cmd, output free_cpu_addr, input ready);
    modport sink   (input valid, input cmd, input free_cpu_addr, output ready);
endinterface

// ----- rtl/dsa_rsp_if.sv -----
// response channel of the descriptor slot allocator
// depends on dsa_pkg
interface dsa_rsp_if import dsa_pkg::*; ();
    logic              valid;
    logic              ready;
    status_t           status;
    logic [IDX_W-1:0]  slot_index;
    logic [ADDR_W-1:0] cpu_addr;
    logic [ADDR_W-1:0] gpu_addr;

    modport source (output valid, output status, output slot_index, output cpu_addr,
                    output gpu_addr, input ready);
    modport sink   (input valid, input status, input slot_index, input cpu_addr,
                    input gpu_addr, output ready);
endinterface

// ----- rtl/descriptor_slot_allocator.sv -----
// descriptor slot allocator: one beat at a time, result held in an output register
// allocate: free stack pop (skipped when the stack is empty), range check, address add, then the result
// free: subtract, range check, the 1-bit/cycle divider, then push; the divider is skipped if saturated
// a new request is taken while an earlier result waits in the output register
// reset clears control state and config; the free stack memory is not cleared
// depends on dsa_pkg, dsa_req_if, dsa_rsp_if, dsa_cfg, dsa_stack, dsa_div
module descriptor_slot_allocator import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_addr,
    input  logic [CFG_DATA_W-1:0] cfg_wdata,
    dsa_req_if.sink               req,
    dsa_rsp_if.source             rsp
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int LW = $clog2(MAX_SLOTS);
    localparam int PW = CW + STRIDE_W;
    localparam int XW = (CW > HEAP_W) ? CW : HEAP_W;

    cfg_t cfg;

    state_t            state_reg, state_next;
    logic [ADDR_W-1:0] addr_reg, addr_next;
    logic [CW-1:0]     nu_reg, nu_next;
    logic [CW-1:0]     idx_reg, idx_next;
    logic [PW-1:0]     off_reg, off_next;
    logic [ADDR_W-1:0] diff_reg, diff_next;
    logic [PW-1:0]     limit_reg, limit_next;
    status_t           res_status_reg, res_status_next;
    logic [CW-1:0]     res_idx_reg, res_idx_next;
    logic [ADDR_W-1:0] res_cpu_reg, res_cpu_next;
    logic [ADDR_W-1:0] res_gpu_reg, res_gpu_next;
    logic              out_valid_reg, out_valid_next;
    status_t           out_status_reg, out_status_next;
    logic [IDX_W-1:0]  out_index_reg, out_index_next;
    logic [ADDR_W-1:0] out_cpu_reg, out_cpu_next;
    logic [ADDR_W-1:0] out_gpu_reg, out_gpu_next;

    logic              stk_push, stk_pop, stk_empty, stk_full;
    logic [CW-1:0]     stk_rdata;
    logic              div_start, div_done;
    logic [LW-1:0]     div_q;
    logic [XW-1:0]     heap_x, nu_x, idx_x, res_idx_x;
    logic [PW-1:0]     off_add;

    dsa_cfg u_cfg
    (
        .clk   (clk),
        .rst_n (rst_n),
        .we    (cfg_we),
        .addr  (cfg_addr),
        .wdata (cfg_wdata),
        .cfg   (cfg)
    );

    dsa_stack #(.MAX_SLOTS(MAX_SLOTS)) u_stack
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (stk_push),
        .pop       (stk_pop),
        .push_data (idx_reg),
        .pop_data  (stk_rdata),
        .empty     (stk_empty),
        .full      (stk_full)
    );

    dsa_div #(.LW(LW), .DW(PW)) u_div
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (diff_reg[PW-1:0]),
        .divisor  (cfg.slot_stride),
        .done     (div_done),
        .quotient (div_q)
    );

    // heap size above capacity acts as capacity
    assign heap_x    = (XW'(cfg.heap_slots) > XW'(MAX_SLOTS)) ? XW'(MAX_SLOTS)
                                                              : XW'(cfg.heap_slots);
    assign nu_x      = XW'(nu_reg);
    assign idx_x     = XW'(idx_reg);
    assign res_idx_x = XW'(res_idx_reg);
    assign off_add   = off_reg;

    assign req.ready = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        addr_next       = addr_reg;
        nu_next         = nu_reg;
        idx_next        = idx_reg;
        off_next        = off_reg;
        diff_next       = diff_reg;
        limit_next      = limit_reg;
        res_status_next = res_status_reg;
        res_idx_next    = res_idx_reg;
        res_cpu_next    = res_cpu_reg;
        res_gpu_next    = res_gpu_reg;
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_index_next  = out_index_reg;
        out_cpu_next    = out_cpu_reg;
        out_gpu_next    = out_gpu_reg;
        stk_push        = 1'b0;
        stk_pop         = 1'b0;
        div_start       = 1'b0;

        if (out_valid_reg && rsp.ready)
            out_valid_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    addr_next    = req.free_cpu_addr;
                    res_idx_next = '0;
                    res_cpu_next = '0;
                    res_gpu_next = '0;
                    if (req.cmd == CMD_ALLOC)
                    begin
                        if (!stk_empty)
                        begin
                            stk_pop    = 1'b1;
                            state_next = S_POP;
                        end
                        else if (nu_x >= heap_x)
                        begin
                            res_status_next = ST_HEAP_FULL;
                            state_next      = S_DONE;
                        end
                        else
                        begin
                            idx_next   = nu_reg;
                            nu_next    = nu_reg + CW'(1);
                            state_next = S_CHK;
                        end
                    end
                    else if (req.free_cpu_addr == '0)
                    begin
                        res_status_next = ST_INVALID;
                        state_next      = S_DONE;
                    end
                    else if (stk_full)
                    begin
                        res_status_next = ST_STACK_FULL;
                        state_next      = S_DONE;
                    end
                    else
                    begin
                        state_next = S_SUB;
                    end
                end
            end
            S_POP:
            begin
                idx_next   = stk_rdata;
                state_next = S_CHK;
            end
            S_CHK:
            begin
                if (idx_x >= heap_x)
                begin
                    res_status_next = ST_RANGE;
                    state_next      = S_DONE;
                end
                else
                begin
                    off_next   = PW'(idx_reg) * PW'(cfg.slot_stride);
                    state_next = S_ADD;
                end
            end
            S_ADD:
            begin
                res_status_next = ST_OK;
                res_idx_next    = idx_reg;
                res_cpu_next    = cfg.cpu_base_addr + ADDR_W'(off_add);
                res_gpu_next    = cfg.shader_visible ? cfg.gpu_base_addr + ADDR_W'(off_add)
                                                     : '0;
                state_next      = S_DONE;
            end
            S_SUB:
            begin
                diff_next  = addr_reg - cfg.cpu_base_addr;
                limit_next = PW'(MAX_SLOTS) * PW'(cfg.slot_stride);
                state_next = S_RNG;
            end
            S_RNG:
            begin
                // huge quotient saturates to capacity
                if (diff_reg >= ADDR_W'(limit_reg))
                begin
                    idx_next   = CW'(MAX_SLOTS);
                    state_next = S_PUSH;
                end
                else
                begin
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    idx_next   = CW'(div_q);
                    state_next = S_PUSH;
                end
            end
            S_PUSH:
            begin
                stk_push        = 1'b1;
                res_status_next = ST_OK;
                res_idx_next    = idx_reg;
                state_next      = S_DONE;
            end
            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_index_next  = res_idx_x[IDX_W-1:0];
                    out_cpu_next    = res_cpu_reg;
                    out_gpu_next    = res_gpu_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            nu_reg        <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            nu_reg        <= nu_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        addr_reg       <= addr_next;
        idx_reg        <= idx_next;
        off_reg        <= off_next;
        diff_reg       <= diff_next;
        limit_reg      <= limit_next;
        res_status_reg <= res_status_next;
        res_idx_reg    <= res_idx_next;
        res_cpu_reg    <= res_cpu_next;
        res_gpu_reg    <= res_gpu_next;
        out_status_reg <= out_status_next;
        out_index_reg  <= out_index_next;
        out_cpu_reg    <= out_cpu_next;
        out_gpu_reg    <= out_gpu_next;
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.status     = out_status_reg;
    assign rsp.slot_index = out_index_reg;
    assign rsp.cpu_addr   = out_cpu_reg;
    assign rsp.gpu_addr   = out_gpu_reg;

endmodule

// ----- rtl/dsa_cfg.sv -----
// configuration registers of the descriptor slot allocator
// depends on dsa_pkg
module dsa_cfg import dsa_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  we,
    input  logic [CFG_IDX_W-1:0]  addr,
    input  logic [CFG_DATA_W-1:0] wdata,
    output cfg_t                  cfg
);

    logic [HEAP_W-1:0]   heap_reg;
    logic [STRIDE_W-1:0] stride_reg;
    logic [ADDR_W-1:0]   cpu_base_reg;
    logic [ADDR_W-1:0]   gpu_base_reg;
    logic                vis_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            heap_reg     <= '0;
            stride_reg   <= STRIDE_RST;
            cpu_base_reg <= '0;
            gpu_base_reg <= '0;
            vis_reg      <= 1'b0;
        end
        else if (we)
        begin
            case (addr)
                REG_HEAP_SLOTS:     heap_reg     <= wdata[HEAP_W-1:0];
                REG_SLOT_STRIDE:    stride_reg   <= wdata[STRIDE_W-1:0];
                REG_CPU_BASE_ADDR:  cpu_base_reg <= wdata[ADDR_W-1:0];
                REG_GPU_BASE_ADDR:  gpu_base_reg <= wdata[ADDR_W-1:0];
                REG_SHADER_VISIBLE: vis_reg      <= wdata[0];
                default:            ;
            endcase
        end
    end

    // zero stride acts as one
    always_comb
    begin
        cfg.heap_slots     = heap_reg;
        cfg.slot_stride    = (stride_reg == '0) ? STRIDE_W'(1) : stride_reg;
        cfg.cpu_base_addr  = cpu_base_reg;
        cfg.gpu_base_addr  = gpu_base_reg;
        cfg.shader_visible = vis_reg;
    end

endmodule

// ----- rtl/dsa_stack.sv -----
// lifo free stack: synchronous memory with a fill count
// depends on dsa_pkg and descriptor_slot_allocator_assert.svh
`include "descriptor_slot_allocator_assert.svh"

module dsa_stack import dsa_pkg::*;
#(
    parameter int MAX_SLOTS = MAX_SLOTS_DEF
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  logic                           push,
    input  logic                           pop,
    input  logic [$clog2(MAX_SLOTS+1)-1:0] push_data,
    output logic [$clog2(MAX_SLOTS+1)-1:0] pop_data,
    output logic                           empty,
    output logic                           full
);

    localparam int CW = $clog2(MAX_SLOTS + 1);
    localparam int AW = $clog2(MAX_SLOTS);

    logic [CW-1:0] mem [MAX_SLOTS];
    logic [CW-1:0] cnt_reg;
    logic [CW-1:0] cnt_next;
    logic [CW-1:0] rd_ptr;
    logic [CW-1:0] pop_data_reg;

    assign rd_ptr = cnt_reg - CW'(1);
    assign empty  = (cnt_reg == '0);
    assign full   = (cnt_reg == CW'(MAX_SLOTS));

    always_comb
    begin
        cnt_next = cnt_reg;
        if (push)
            cnt_next = cnt_reg + CW'(1);
        else if (pop)
            cnt_next = rd_ptr;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            cnt_reg <= '0;
        else
            cnt_reg <= cnt_next;
    end

    always_ff @(posedge clk)
    begin
        if (push)
            mem[cnt_reg[AW-1:0]] <= push_data;
        if (pop)
            pop_data_reg <= mem[rd_ptr[AW-1:0]];
    end

    assign pop_data = pop_data_reg;

    `DSA_ASSERT_NEVER(a_push_pop, push && pop, "push and pop in one cycle")
    `DSA_ASSERT_IMP(a_push_full, push, cnt_reg != CW'(MAX_SLOTS), "push into full stack")
    `DSA_ASSERT_IMP(a_pop_empty, pop, cnt_reg != '0, "pop from empty stack")
    `DSA_ASSERT_NXT(a_pop_step, pop, cnt_reg == $past(cnt_reg) - CW'(1), "pop count step")

endmodule

// ----- rtl/dsa_div.sv -----
// restoring divider, one quotient bit per cycle
// depends on dsa_pkg; dividend must be below divisor * 2**LW
module dsa_div import dsa_pkg::*;
#(
    parameter int LW = 10,
    parameter int DW = 24
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    input  logic [DW-1:0]       dividend,
    input  logic [STRIDE_W-1:0] divisor,
    output logic                done,
    output logic [LW-1:0]       quotient
);

    localparam int CNW = (LW > 1) ? $clog2(LW) : 1;

    logic [DW-1:0]  rem_reg, rem_next;
    logic [DW-1:0]  dsr_reg, dsr_next;
    logic [LW-1:0]  q_reg, q_next;
    logic [CNW-1:0] cnt_reg, cnt_next;
    logic           busy_reg, busy_next;
    logic           done_reg, done_next;
    logic           ge;

    assign ge = (rem_reg >= dsr_reg);

    always_comb
    begin
        rem_next  = rem_reg;
        dsr_next  = dsr_reg;
        q_next    = q_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = dividend;
            dsr_next  = DW'(divisor) << (LW - 1);
            q_next    = '0;
            cnt_next  = CNW'(LW - 1);
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (ge)
                rem_next = rem_reg - dsr_reg;
            q_next   = LW'({q_reg, ge});
            dsr_next = dsr_reg >> 1;
            cnt_next = cnt_reg - CNW'(1);
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        dsr_reg <= dsr_next;
        q_reg   <= q_next;
    end

    assign done     = done_reg;
    assign quotient = q_reg;

endmodule
